// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

	localparam int TAG_W      = 32;
	localparam int PRIO_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int OCC_W      = 5;
	localparam int CAPACITY_D = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, fill counter and result register.
// Bounded priority queue held as a chain of CAPACITY compare-and-shift cells kept in
// ascending priority order; equal priorities leave in arrival order. Every request
// (insert or delete head) is taken at once, so busy is never raised and a
// request may be issued on every clock. Its result appears on the result ports, marked
// by done, in the cycle after the request is taken and for that cycle only; the
// receiver must take it then. Insert and delete each complete without a busy state because
// every cell compares against the request and shifts in parallel. A delete of an
// empty queue reports underflow and an insert into a full one reports overflow and
// drops the item; occupancy shows the count after the request, low five bits.
`default_nettype none
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_D
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire                              operation,
	input  wire [spq_pkg::TAG_W-1:0]         item_tag,
	input  wire [spq_pkg::PRIO_W-1:0]        priority_req,
	output logic                             done,
	output logic [spq_pkg::TAG_W-1:0]        out_tag,
	output logic [spq_pkg::PRIO_W-1:0]       out_priority,
	output logic [spq_pkg::STATUS_W-1:0]     status,
	output logic [spq_pkg::OCC_W-1:0]        occupancy
);

	localparam int COUNT_W = $clog2(CAPACITY + 1);
	localparam logic [COUNT_W-1:0] FULL = COUNT_W'(CAPACITY);

	logic [COUNT_W-1:0]        count_q;
	logic [COUNT_W-1:0]        count_d;
	logic                      done_q;
	logic [spq_pkg::TAG_W-1:0] tag_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;
	spq_pkg::status_t          status_q;
	spq_pkg::status_t          status_d;
	spq_pkg::cell_ctrl_t       ctrl;
	logic                      is_del;
	logic                      empty;
	logic                      full;
	logic [COUNT_W+spq_pkg::OCC_W-1:0] occ_ext;

	logic                       gt_w   [CAPACITY];
	logic [spq_pkg::TAG_W-1:0]  tag_w  [CAPACITY];
	logic [spq_pkg::PRIO_W-1:0] prio_w [CAPACITY];

	assign busy   = 1'b0;
	assign is_del = (spq_pkg::op_t'(operation) == spq_pkg::OP_DELETE);
	assign empty  = (count_q == '0);
	assign full   = (count_q == FULL);

	always_comb begin
		ctrl.ins = start && !is_del && !full;
		ctrl.del = start && is_del && !empty;
		count_d  = count_q;
		status_d = spq_pkg::ST_DONE;
		if (ctrl.ins) begin
			count_d = count_q + COUNT_W'(1);
		end else if (ctrl.del) begin
			count_d = count_q - COUNT_W'(1);
		end
		if (is_del && empty) begin
			status_d = spq_pkg::ST_UNDERFLOW;
		end else if (!is_del && full) begin
			status_d = spq_pkg::ST_OVERFLOW;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                       l_gt;
		logic [spq_pkg::TAG_W-1:0]  l_tag;
		logic [spq_pkg::PRIO_W-1:0] l_prio;
		logic [spq_pkg::TAG_W-1:0]  r_tag;
		logic [spq_pkg::PRIO_W-1:0] r_prio;

		if (i == 0) begin : g_head
			assign l_gt   = 1'b0;
			assign l_tag  = item_tag;
			assign l_prio = priority_req;
		end else begin : g_mid
			assign l_gt   = gt_w[i-1];
			assign l_tag  = tag_w[i-1];
			assign l_prio = prio_w[i-1];
		end

		// Tail slot keeps its contents on delete; it drops out of range anyway.
		if (i == CAPACITY - 1) begin : g_tail
			assign r_tag  = tag_w[i];
			assign r_prio = prio_w[i];
		end else begin : g_body
			assign r_tag  = tag_w[i+1];
			assign r_prio = prio_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (COUNT_W'(i) < count_q),
			.req_tag    (item_tag),
			.req_prio   (priority_req),
			.left_gt    (l_gt),
			.left_tag   (l_tag),
			.left_prio  (l_prio),
			.right_tag  (r_tag),
			.right_prio (r_prio),
			.gt         (gt_w[i]),
			.tag        (tag_w[i]),
			.prio       (prio_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= spq_pkg::ST_DONE;
		end else begin
			done_q <= start;
			if (start) begin
				count_q  <= count_d;
				status_q <= status_d;
			end
		end
	end

	// Head is read out only on a successful delete.
	always_ff @(posedge clk) begin
		if (start) begin
			tag_q  <= ctrl.del ? tag_w[0]  : '0;
			prio_q <= ctrl.del ? prio_w[0] : '0;
		end
	end

	assign occ_ext      = {{spq_pkg::OCC_W{1'b0}}, count_q};
	assign done         = done_q;
	assign out_tag      = tag_q;
	assign out_priority = prio_q;
	assign status       = status_q;
	assign occupancy    = occ_ext[spq_pkg::OCC_W-1:0];

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q == $past(start))
		else $error("result strobe does not follow request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("fill count beyond capacity");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		start && !is_del && full |=> status_q == spq_pkg::ST_OVERFLOW
			&& $stable(count_q))
		else $error("insert into full queue not reported as overflow");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= COUNT_W'(2) |-> prio_w[0] <= prio_w[1])
		else $error("head entries out of order");

endmodule
`default_nettype wire

// ===== design/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert, left on delete.
`default_nettype none
module spq_cell (
	input  wire                            clk,
	input  wire spq_pkg::cell_ctrl_t       ctrl,
	input  wire                            valid,
	input  wire [spq_pkg::TAG_W-1:0]       req_tag,
	input  wire [spq_pkg::PRIO_W-1:0]      req_prio,
	input  wire                            left_gt,
	input  wire [spq_pkg::TAG_W-1:0]       left_tag,
	input  wire [spq_pkg::PRIO_W-1:0]      left_prio,
	input  wire [spq_pkg::TAG_W-1:0]       right_tag,
	input  wire [spq_pkg::PRIO_W-1:0]      right_prio,
	output logic                           gt,
	output logic [spq_pkg::TAG_W-1:0]      tag,
	output logic [spq_pkg::PRIO_W-1:0]     prio
);

	logic [spq_pkg::TAG_W-1:0]  tag_q;
	logic [spq_pkg::PRIO_W-1:0] prio_q;

	// An empty slot counts as "after" any request, so the chain stays monotonic.
	assign gt   = !valid || (prio_q > req_prio);
	assign tag  = tag_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (ctrl.del) begin
			tag_q  <= right_tag;
			prio_q <= right_prio;
		end else if (ctrl.ins && gt) begin
			if (left_gt) begin
				tag_q  <= left_tag;
				prio_q <= left_prio;
			end else begin
				tag_q  <= req_tag;
				prio_q <= req_prio;
			end
		end
	end

endmodule
`default_nettype wire
